// ----- design/signed_integer_to_decimal_ascii_core_assert.svh -----
// Assertion macros used by the decimal ASCII converter controller, sida_ctrl.
// Self-contained; the assertions compile away when SYNTHESIS is defined.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define SIDA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sida assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SIDA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sida assertion failed");

`else

`define SIDA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SIDA_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ----- design/sida_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies; used by sida_ctrl, sida_dp and the top level.
package sida_pkg;

  // Field widths.
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 6;
  localparam int WORD_DIGITS = 10;
  localparam int SHIFT_CNT_W = 5;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 6'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic pick;
    logic emit_sign;
    logic emit_digit;
  } sida_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_neg;
    logic idx_zero;
    logic out_free;
  } sida_status_t;

endpackage

// ----- design/sida_dp.sv -----
// Datapath of the decimal ASCII converter: magnitude, double-dabble shifter,
// digit index and output register. Depends on sida_pkg.
module sida_dp #(
  parameter int KEEP_DIGITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  input  sida_pkg::sida_cmd_t                cmd,
  output sida_pkg::sida_status_t             status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [sida_pkg::CHAR_W-1:0]        ascii_char,
  output logic                               last
);
  import sida_pkg::*;

  localparam int BCD_W = 4 * KEEP_DIGITS;
  localparam int IDX_W = (KEEP_DIGITS > 1) ? $clog2(KEEP_DIGITS) : 1;

  logic [VALUE_W-1:0] value_u;
  logic [VALUE_W-1:0] value_mag;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic               ovf;
  logic               neg;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   start_idx;
  logic [3:0]         cur_digit;

  // Magnitude of the input; the most negative value wraps to 2^31.
  assign value_u   = unsigned'(value);
  assign value_mag = value_u[VALUE_W-1] ? ('0 - value_u) : value_u;

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < KEEP_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // First digit to emit: the top nonzero digit, or the top kept digit when
  // the magnitude has more digits than are kept.
  always_comb begin
    start_idx = '0;
    for (int i = 0; i < KEEP_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        start_idx = IDX_W'(i);
      end
    end
    if (ovf) begin
      start_idx = IDX_W'(KEEP_DIGITS - 1);
    end
  end

  assign cur_digit = bcd[idx*4 +: 4];

  // Conversion registers. A bit shifted out of the top kept digit marks
  // digits that were dropped.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value_mag;
      neg <= value_u[VALUE_W-1];
      bcd <= '0;
      ovf <= 1'b0;
    end else if (cmd.shift) begin
      mag <= {mag[VALUE_W-2:0], 1'b0};
      bcd <= {adj[BCD_W-2:0], mag[VALUE_W-1]};
      ovf <= ovf | adj[BCD_W-1];
    end
    if (cmd.pick) begin
      idx <= start_idx;
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
  end

  // Output register: loaded on an emit, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii_char <= CHR_MINUS;
      last       <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii_char <= CHR_ZERO + {2'b00, cur_digit};
      last       <= (idx == '0);
    end
  end

  // Status back to the controller.
  assign status.is_neg   = neg;
  assign status.idx_zero = (idx == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- design/sida_ctrl.sv -----
// Controller of the decimal ASCII converter: input handshake, shift count
// and character sequencing. Depends on sida_pkg and the assertion header.
`include "signed_integer_to_decimal_ascii_core_assert.svh"

module sida_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output sida_pkg::sida_cmd_t    cmd,
  input  sida_pkg::sida_status_t status
);
  import sida_pkg::*;

  localparam logic [SHIFT_CNT_W-1:0] SHIFT_LAST = SHIFT_CNT_W'(VALUE_W - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CONV  = 4'b0010,
    S_SIGN  = 4'b0100,
    S_DIGIT = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [SHIFT_CNT_W-1:0] cnt;
  logic [SHIFT_CNT_W-1:0] cnt_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == SHIFT_LAST) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        cmd.pick = 1'b1;
        if (!status.is_neg) begin
          state_next = S_DIGIT;
        end else if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.idx_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and shift counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // A transfer in starts a fresh conversion.
  `SIDA_ASSERT_NXT(a_load_starts, clk, rst, in_valid && in_ready, state == S_CONV && cnt == '0)
  // No character leaves while the shifter runs.
  `SIDA_ASSERT_IMP(a_conv_quiet, clk, rst, state == S_CONV, !cmd.emit_sign && !cmd.emit_digit)
  // A minus sign is only emitted for a negative input.
  `SIDA_ASSERT_IMP(a_sign_neg, clk, rst, cmd.emit_sign, status.is_neg)
  // The last digit returns the controller to idle.
  `SIDA_ASSERT_NXT(a_last_idle, clk, rst, cmd.emit_digit && status.idx_zero, state == S_IDLE)

endmodule

// ----- design/signed_integer_to_decimal_ascii_core.sv -----
// Signed 32-bit integer to decimal ASCII text. After an input transfer the
// value is converted by a 32-step bit-serial double-dabble shifter, a pick
// state then selects the first digit, and then one character per cycle, while
// the receiver does not stall, leaves through a registered output: an optional
// minus sign, then the digits most significant first without leading zeros,
// "0" for zero, with last set on the final character. The minus sign leaves
// in the same cycle that picks the first digit. A new input is taken while
// the final character still waits.
// When MAX_DIGITS is below 10, only the low MAX_DIGITS digits are kept.
module signed_integer_to_decimal_ascii_core #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sida_pkg::CHAR_W-1:0]         ascii_char,
  output logic                                last
);
  import sida_pkg::*;

  localparam int KEEP_DIGITS = (MAX_DIGITS < WORD_DIGITS) ? MAX_DIGITS : WORD_DIGITS;

  sida_cmd_t    cmd;
  sida_status_t status;

  // Sequencing.
  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Conversion and output register.
  sida_dp #(
    .KEEP_DIGITS (KEEP_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .ascii_char (ascii_char),
    .last       (last)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for signed_integer_to_decimal_ascii_core.
// Predicts the decimal text of every value transfer and checks each character
// transfer against it. Depends on sida_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sida_pkg::*;

  localparam int MAX_DIGITS  = 10;
  localparam int IDLE_LIMIT  = 1500;
  localparam int TAIL_CYCLES = 60;
  localparam int N_RANDOM    = 400;
  localparam int REPORT_MAX  = 10;

  // One character of predicted decimal text.
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  // One value waiting to be sent; drain_first holds it until all text is out.
  typedef struct {
    logic signed [VALUE_W-1:0] number;
    bit                        drain_first;
  } pending_value_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CHAR_W-1:0]         ascii_char;
  logic                      last;

  pending_value_t values_to_send[$];
  text_char_t     expected_text[$];

  int unsigned n_presented = 0;
  int unsigned n_values_taken = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  logic [7:0]  rx_pattern = 8'b1011_0110;

  signed_integer_to_decimal_ascii_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ascii_char(ascii_char),
    .last      (last)
  );

  always #10 clk = ~clk;

  // Appends the decimal text of one signed value to the expected text.
  function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W:0] mag;
    logic [3:0]       digit [WORD_DIGITS];
    int               count;
    int               keep;
    text_char_t       c;
    count = 0;
    mag = v[VALUE_W-1] ? ({1'b1, {VALUE_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
    while (mag != 0 && count < WORD_DIGITS) begin
      digit[count] = 4'(mag % 10);
      mag = mag / 10;
      count++;
    end
    keep = (count > MAX_DIGITS) ? MAX_DIGITS : count;
    // The sign only ends the text when no digit is kept at all.
    if (v[VALUE_W-1]) begin
      c.code = CHR_MINUS;
      c.is_last = (count != 0 && keep == 0);
      expected_text.push_back(c);
    end
    if (count == 0) begin
      c.code = CHR_ZERO;
      c.is_last = 1'b1;
      expected_text.push_back(c);
    end else begin
      for (int i = keep - 1; i >= 0; i--) begin
        c.code = CHR_ZERO + {2'b00, digit[i]};
        c.is_last = (i == 0);
        expected_text.push_back(c);
      end
    end
  endfunction

  // Mostly values of a random digit count, some raw words and some corners.
  function automatic logic signed [VALUE_W-1:0] random_value();
    int unsigned       pick;
    int unsigned       n_dig;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   mag;
    bit                neg;
    pick = $urandom_range(0, 9);
    if (pick < 2) return $urandom();
    if (pick == 2) begin
      case ($urandom_range(0, 5))
        0: return 32'sh0000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh8000_0000;
        3: return 32'sh8000_0001;
        4: return 32'sh0000_0001;
        default: return 32'shFFFF_FFFF;
      endcase
    end
    n_dig = $urandom_range(1, 10);
    neg = 1'($urandom_range(0, 1));
    lo = 1;
    repeat (n_dig - 1) lo = lo * 10;
    hi = (n_dig == 10) ? (neg ? 64'd2147483648 : 64'd2147483647) : lo * 10 - 1;
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  // Sender: bursts of random length with random gaps, one value per transfer.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && n_values_taken != n_presented) begin
      // Hold the current value until its transfer.
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (values_to_send.size() == 0) begin
      in_valid <= 1'b0;
    end else if (values_to_send[0].drain_first && expected_text.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      value <= values_to_send[0].number;
      values_to_send.pop_front();
      n_presented++;
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(40, 80);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        end
      end
    end
  end

  // Receiver: switches at random among its own stall patterns.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          out_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predicts on each value transfer and checks each character transfer.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("ERROR: unexpected character %0d last %0b", ascii_char, last);
        end else begin
          want = expected_text.pop_front();
          if (ascii_char !== want.code || last !== want.is_last) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
              $display("ERROR: character expected %0d last %0b, got %0d last %0b",
                       want.code, want.is_last, ascii_char, last);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_decimal_text(value);
        n_values_taken <= n_values_taken + 1;
      end
      // Watchdog on cycles without any transfer.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic signed [VALUE_W-1:0] directed [];
    pending_value_t p;
    directed = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
      32'sd12345, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
      32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd1000000007,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sd42, -32'sd5, 32'sd0, -32'sd1000000000
    };
    foreach (directed[i]) begin
      p.number = directed[i];
      p.drain_first = (i == 12);
      values_to_send.push_back(p);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      p.number = random_value();
      p.drain_first = (i == 150) || ($urandom_range(0, 59) == 0);
      values_to_send.push_back(p);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (values_to_send.size() != 0 || n_values_taken != n_presented ||
           expected_text.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
